[design/dtp_pkg.sv]
// shared types and constants for the date-time text parser
`timescale 1ns / 1ps

package dtp_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0]  t_byte;

    // number of kept segments and packed binary length
    localparam int unsigned SEG_NUM = 7;
    localparam int unsigned RAW_NUM = 8;

    // result format codes
    localparam logic [2:0] FMT_BAD       = 3'd0;
    localparam logic [2:0] FMT_DATE      = 3'd1;
    localparam logic [2:0] FMT_TIME      = 3'd2;
    localparam logic [2:0] FMT_DATE_TIME = 3'd3;
    localparam logic [2:0] FMT_TIME_DATE = 3'd4;
    localparam logic [2:0] FMT_DT_FRAC   = 3'd5;
    localparam logic [2:0] FMT_TF_DATE   = 3'd6;
    localparam logic [2:0] FMT_BINARY    = 3'd7;

    // character codes
    localparam t_byte CH_NUL   = 8'h00;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_COMMA = 8'h2C;
    localparam t_byte CH_DOT   = 8'h2E;
    localparam t_byte CH_SLASH = 8'h2F;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_NINE  = 8'h39;
    localparam t_byte CH_COLON = 8'h3A;

    // time constants
    localparam t_word SECS_PER_HOUR = 32'd3600;
    localparam t_word SECS_PER_MIN  = 32'd60;

    // digit count that maps to a unit scale (six fraction digits)
    localparam logic [2:0] DIG_UNIT = 3'd6;

    // fraction scale to microseconds by digit count; over six digits gives zero
    function automatic logic [19:0] frac_scale(input logic [2:0] digits);
        logic [19:0] scale;
        case (digits)
            3'd0:    scale = 20'd1000000;
            3'd1:    scale = 20'd100000;
            3'd2:    scale = 20'd10000;
            3'd3:    scale = 20'd1000;
            3'd4:    scale = 20'd100;
            3'd5:    scale = 20'd10;
            3'd6:    scale = 20'd1;
            default: scale = 20'd0;
        endcase
        return scale;
    endfunction

endpackage

[design/datetime_text_parser.sv]
// date-time text parser top: byte scanner, snapshot, product stage, result register
// a result passes the snapshot, product and result registers after its terminator
// throughput: one byte word per cycle while the result side is not stalled
// the rate is set by the scanner, which updates the segment state once per byte
// reset (synchronous, active low) clears segment state, counts and all valid flags
`timescale 1ns / 1ps

module datetime_text_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_year,
    output logic [31:0] o_month,
    output logic [31:0] o_day,
    output logic [31:0] o_seconds_of_day,
    output logic [31:0] o_microseconds,
    output logic [2:0]  o_format_code
);

    // pipeline advance and input handshake
    logic w_adv;
    logic w_acc;
    logic w_term;

    assign w_adv  = !o_valid || !i_stall;
    assign o_stall = !w_adv;
    assign w_acc  = i_valid && w_adv;
    assign w_term = (i_char_code == dtp_pkg::CH_NUL);

    // scanner state
    dtp_pkg::t_word r_seg_val [dtp_pkg::SEG_NUM];
    dtp_pkg::t_byte r_seg_dlm [dtp_pkg::SEG_NUM];
    logic [2:0]     r_seg_dig [dtp_pkg::SEG_NUM];
    logic [2:0]     r_seg_count;
    dtp_pkg::t_byte r_raw [dtp_pkg::RAW_NUM];
    logic [3:0]     r_byte_count;
    logic           r_leading_blank;

    dtp_pkg::t_word n_seg_val [dtp_pkg::SEG_NUM];
    dtp_pkg::t_byte n_seg_dlm [dtp_pkg::SEG_NUM];
    logic [2:0]     n_seg_dig [dtp_pkg::SEG_NUM];
    logic [2:0]     n_seg_count;
    logic [3:0]     n_byte_count;
    logic           n_leading_blank;

    logic           w_is_digit;
    logic [3:0]     w_digit;

    assign w_is_digit = (i_char_code >= dtp_pkg::CH_ZERO) &&
                        (i_char_code <= dtp_pkg::CH_NINE);
    assign w_digit    = 4'(i_char_code - dtp_pkg::CH_ZERO);

    // per-byte segment update
    always_comb begin
        for (int i = 0; i < dtp_pkg::SEG_NUM; i++) begin
            n_seg_val[i] = r_seg_val[i];
            n_seg_dlm[i] = r_seg_dlm[i];
            n_seg_dig[i] = r_seg_dig[i];
        end
        n_seg_count     = r_seg_count;
        n_byte_count    = r_byte_count;
        n_leading_blank = r_leading_blank;
        if (r_byte_count <= 4'(dtp_pkg::RAW_NUM)) begin
            n_byte_count = r_byte_count + 4'd1;
        end
        if (i_char_code != dtp_pkg::CH_SPACE) begin
            n_leading_blank = 1'b0;
            if (r_seg_count < 3'(dtp_pkg::SEG_NUM)) begin
                if (w_is_digit) begin
                    for (int i = 0; i < dtp_pkg::SEG_NUM; i++) begin
                        if (r_seg_count == 3'(i)) begin
                            n_seg_val[i] = (r_seg_val[i] << 3) + (r_seg_val[i] << 1) +
                                           {28'd0, w_digit};
                            if (r_seg_dig[i] != 3'd7) begin
                                n_seg_dig[i] = r_seg_dig[i] + 3'd1;
                            end
                        end
                    end
                end else begin
                    for (int i = 0; i < dtp_pkg::SEG_NUM; i++) begin
                        if (r_seg_count == 3'(i)) begin
                            n_seg_dlm[i] = i_char_code;
                        end
                    end
                    n_seg_count = r_seg_count + 3'd1;
                end
            end
        end
    end

    // scanner registers; a terminator returns them to reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dtp_pkg::SEG_NUM; i++) begin
                r_seg_val[i] <= '0;
                r_seg_dlm[i] <= '0;
                r_seg_dig[i] <= '0;
            end
            r_seg_count     <= '0;
            r_byte_count    <= '0;
            r_leading_blank <= 1'b1;
        end else if (w_acc) begin
            if (w_term) begin
                for (int i = 0; i < dtp_pkg::SEG_NUM; i++) begin
                    r_seg_val[i] <= '0;
                    r_seg_dlm[i] <= '0;
                    r_seg_dig[i] <= '0;
                end
                r_seg_count     <= '0;
                r_byte_count    <= '0;
                r_leading_blank <= 1'b1;
            end else begin
                for (int i = 0; i < dtp_pkg::SEG_NUM; i++) begin
                    r_seg_val[i] <= n_seg_val[i];
                    r_seg_dlm[i] <= n_seg_dlm[i];
                    r_seg_dig[i] <= n_seg_dig[i];
                end
                r_seg_count     <= n_seg_count;
                r_byte_count    <= n_byte_count;
                r_leading_blank <= n_leading_blank;
            end
        end
    end

    // raw byte capture for the packed binary form
    always_ff @(posedge i_clk) begin
        if (w_acc && !w_term) begin
            for (int i = 0; i < dtp_pkg::RAW_NUM; i++) begin
                if (r_byte_count == 4'(i)) begin
                    r_raw[i] <= i_char_code;
                end
            end
        end
    end

    // layout match at the terminator
    logic       w_dd;
    logic       w_tt;
    logic       w_text_ok;
    logic [2:0] w_fmt;

    assign w_dd = (r_seg_dlm[0] == dtp_pkg::CH_SLASH) && (r_seg_dlm[1] == dtp_pkg::CH_SLASH);
    assign w_tt = (r_seg_dlm[0] == dtp_pkg::CH_COLON) && (r_seg_dlm[1] == dtp_pkg::CH_COLON);
    assign w_text_ok = !r_leading_blank && (r_seg_count < 3'(dtp_pkg::SEG_NUM));

    always_comb begin
        w_fmt = dtp_pkg::FMT_BAD;
        if (r_byte_count == 4'(dtp_pkg::RAW_NUM)) begin
            w_fmt = dtp_pkg::FMT_BINARY;
        end else if (w_text_ok) begin
            case (r_seg_count)
                3'd2: begin
                    if (w_dd) begin
                        w_fmt = dtp_pkg::FMT_DATE;
                    end else if (w_tt) begin
                        w_fmt = dtp_pkg::FMT_TIME;
                    end
                end
                3'd5: begin
                    if (w_dd && r_seg_dlm[2] == dtp_pkg::CH_COMMA &&
                        r_seg_dlm[3] == dtp_pkg::CH_COLON &&
                        r_seg_dlm[4] == dtp_pkg::CH_COLON) begin
                        w_fmt = dtp_pkg::FMT_DATE_TIME;
                    end else if (w_tt && r_seg_dlm[2] == dtp_pkg::CH_COMMA &&
                                 r_seg_dlm[3] == dtp_pkg::CH_SLASH &&
                                 r_seg_dlm[4] == dtp_pkg::CH_SLASH) begin
                        w_fmt = dtp_pkg::FMT_TIME_DATE;
                    end
                end
                3'd6: begin
                    if (w_dd && r_seg_dlm[2] == dtp_pkg::CH_COMMA &&
                        r_seg_dlm[3] == dtp_pkg::CH_COLON &&
                        r_seg_dlm[4] == dtp_pkg::CH_COLON &&
                        r_seg_dlm[5] == dtp_pkg::CH_DOT) begin
                        w_fmt = dtp_pkg::FMT_DT_FRAC;
                    end else if (w_tt && r_seg_dlm[2] == dtp_pkg::CH_DOT &&
                                 r_seg_dlm[3] == dtp_pkg::CH_COMMA &&
                                 r_seg_dlm[4] == dtp_pkg::CH_SLASH &&
                                 r_seg_dlm[5] == dtp_pkg::CH_SLASH) begin
                        w_fmt = dtp_pkg::FMT_TF_DATE;
                    end
                end
                default: w_fmt = dtp_pkg::FMT_BAD;
            endcase
        end
    end

    // field selection by layout
    dtp_pkg::t_word w_hr, w_mn, w_sc, w_dy, w_mo, w_yr, w_fv;
    logic [2:0]     w_fd;

    always_comb begin
        w_hr = '0;
        w_mn = '0;
        w_sc = '0;
        w_dy = '0;
        w_mo = '0;
        w_yr = '0;
        w_fv = '0;
        w_fd = '0;
        case (w_fmt)
            dtp_pkg::FMT_DATE: begin
                w_dy = r_seg_val[0]; w_mo = r_seg_val[1]; w_yr = r_seg_val[2];
            end
            dtp_pkg::FMT_TIME: begin
                w_hr = r_seg_val[0]; w_mn = r_seg_val[1]; w_sc = r_seg_val[2];
            end
            dtp_pkg::FMT_DATE_TIME: begin
                w_dy = r_seg_val[0]; w_mo = r_seg_val[1]; w_yr = r_seg_val[2];
                w_hr = r_seg_val[3]; w_mn = r_seg_val[4]; w_sc = r_seg_val[5];
            end
            dtp_pkg::FMT_TIME_DATE: begin
                w_hr = r_seg_val[0]; w_mn = r_seg_val[1]; w_sc = r_seg_val[2];
                w_dy = r_seg_val[3]; w_mo = r_seg_val[4]; w_yr = r_seg_val[5];
            end
            dtp_pkg::FMT_DT_FRAC: begin
                w_dy = r_seg_val[0]; w_mo = r_seg_val[1]; w_yr = r_seg_val[2];
                w_hr = r_seg_val[3]; w_mn = r_seg_val[4]; w_sc = r_seg_val[5];
                w_fv = r_seg_val[6]; w_fd = r_seg_dig[6];
            end
            dtp_pkg::FMT_TF_DATE: begin
                w_hr = r_seg_val[0]; w_mn = r_seg_val[1]; w_sc = r_seg_val[2];
                w_fv = r_seg_val[3]; w_fd = r_seg_dig[3];
                w_dy = r_seg_val[4]; w_mo = r_seg_val[5]; w_yr = r_seg_val[6];
            end
            dtp_pkg::FMT_BINARY: begin
                // packed form: microseconds pass through with a unit scale
                w_dy = {27'd0, r_raw[0][4:0]};
                w_mo = {28'd0, r_raw[1][7:4]};
                w_yr = {20'd0, r_raw[1][3:0], r_raw[2]};
                w_fv = {12'd0, r_raw[3], r_raw[4], r_raw[5][7:4]};
                w_fd = dtp_pkg::DIG_UNIT;
                w_sc = {15'd0, r_raw[5][0], r_raw[6], r_raw[7]};
            end
            default: begin
                w_hr = '0;
            end
        endcase
    end

    // snapshot stage
    logic           r_s1_valid;
    dtp_pkg::t_word r_s1_hr, r_s1_mn, r_s1_sc, r_s1_dy, r_s1_mo, r_s1_yr, r_s1_fv;
    logic [2:0]     r_s1_fd;
    logic [2:0]     r_s1_fmt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_acc && w_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_hr  <= w_hr;
            r_s1_mn  <= w_mn;
            r_s1_sc  <= w_sc;
            r_s1_dy  <= w_dy;
            r_s1_mo  <= w_mo;
            r_s1_yr  <= w_yr;
            r_s1_fv  <= w_fv;
            r_s1_fd  <= w_fd;
            r_s1_fmt <= w_fmt;
        end
    end

    // product stage
    logic           r_s2_valid;
    dtp_pkg::t_word r_s2_hp, r_s2_mp, r_s2_sc, r_s2_us, r_s2_dy, r_s2_mo, r_s2_yr;
    logic [2:0]     r_s2_fmt;
    dtp_pkg::t_word w_hp, w_mp;
    logic [51:0]    w_us_prod;

    assign w_hp      = r_s1_hr * dtp_pkg::SECS_PER_HOUR;
    assign w_mp      = r_s1_mn * dtp_pkg::SECS_PER_MIN;
    assign w_us_prod = {20'd0, r_s1_fv} * {32'd0, dtp_pkg::frac_scale(r_s1_fd)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_hp  <= w_hp;
            r_s2_mp  <= w_mp;
            r_s2_sc  <= r_s1_sc;
            r_s2_us  <= w_us_prod[31:0];
            r_s2_dy  <= r_s1_dy;
            r_s2_mo  <= r_s1_mo;
            r_s2_yr  <= r_s1_yr;
            r_s2_fmt <= r_s1_fmt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_adv) begin
            o_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_year           <= r_s2_yr;
            o_month          <= r_s2_mo;
            o_day            <= r_s2_dy;
            o_seconds_of_day <= r_s2_hp + r_s2_mp + r_s2_sc;
            o_microseconds   <= r_s2_us;
            o_format_code    <= r_s2_fmt;
        end
    end

`ifndef SYNTH
    // a bad format carries all-zero fields
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_format_code == dtp_pkg::FMT_BAD) |->
        (o_year == '0 && o_month == '0 && o_day == '0 &&
         o_seconds_of_day == '0 && o_microseconds == '0))
        else $error("bad format with nonzero fields");

    // a time-only result carries no date
    a_time_no_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_format_code == dtp_pkg::FMT_TIME) |->
        (o_year == '0 && o_month == '0 && o_day == '0))
        else $error("time-only result with a date");

    // only a terminator starts a result
    a_term_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !(i_valid && i_char_code == dtp_pkg::CH_NUL)) |=> !r_s1_valid)
        else $error("result started without a terminator");

    // a terminator returns the scanner to its idle state
    a_term_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_term) |=> (r_byte_count == 4'd0 && r_seg_count == 3'd0 &&
                               r_leading_blank))
        else $error("scanner not cleared after terminator");
`endif

endmodule
